// File: rtl/bfas_pkg.sv
// shared constants and a saturation function for the biharmonic field acceleration stencil
package bfas_pkg;

    localparam int DATA_W      = 48;
    localparam int CFG_W       = 47;
    localparam int MAX_ROW_DEF = 4096;
    localparam int FRAC_DEF    = 24;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 144;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ISPSQ = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STIFF = 2'd3;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // clamp a wide signed value into the data range
    function automatic logic [DATA_W:0] sat_wide(input logic signed [DATA_W+3:0] v);
        logic [DATA_W:0] r;
        if (v > $signed({{4{1'b0}}, SMAX}))
            r = {1'b1, SMAX};
        else if (v < $signed({{4{1'b1}}, SMIN}))
            r = {1'b1, SMIN};
        else
            r = {1'b0, v[DATA_W-1:0]};
        return r;
    endfunction

endpackage

// File: rtl/biharmonic_field_accel_stencil.sv
// top level of the biharmonic field acceleration stencil
//
// Usage: points of a row enter on s_axis (one point per transfer, tlast marks
// the row end); accelerations leave on m_axis, each result trailing its input
// by two points. The final point of a row also flushes two zero results (only
// one in a one-point row), the last one carrying tlast. Registers are written
// on the cfg channel, which is ready only while no point is being worked on.
// An interior point (four or more earlier points in the row) runs 18 products
// through one shared 48x48 multiplier, fed in 24x24 partial products: each
// product takes an operand load, four partial products and a store. Three
// quotients follow on a one-bit-a-cycle restoring divider, each a load, one
// step per quotient bit and a finish, then the point goes to an emit state.
// A boundary point skips the multiplier and divider and goes straight to the
// emit state with zero accelerations; a row end adds one flush state per
// flushed result.
// s_axis_tready is low while a point is being worked on. A stalled m_axis
// holds the result register and only delays the next emit; nothing is lost.
// Reset clears the window, the point counter and restores register defaults.
module biharmonic_field_accel_stencil #(
    parameter int MAX_ROW   = bfas_pkg::MAX_ROW_DEF,
    parameter int FRAC_BITS = bfas_pkg::FRAC_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // field_one, field_two, field_three
    input  logic [bfas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // accel_one, accel_two, accel_three
    output logic [bfas_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // clipped
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bfas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfas_pkg::DATA_W-1:0]          cfg_data
);
    import bfas_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW + 1);
    localparam int DIVN  = DATA_W + FRAC_BITS;
    localparam int DCW   = $clog2(DIVN + 1);
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MWAIT, S_DIV, S_DFIN, S_EMIT, S_FLUSH1, S_FLUSH2
    } state_t;

    // micro-operation steps of the computed path
    typedef enum logic [4:0] {
        U_P12, U_P, U_PP, U_KPP, U_DEN2, U_MP,
        U_DP0, U_DP1, U_DP2, U_G0, U_G1, U_G2,
        U_LAP0, U_BIH0, U_LAP1, U_BIH1, U_LAP2, U_BIH2, U_Q0, U_Q1, U_Q2, U_DONE
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic signed [DATA_W-1:0] pot_reg;
    logic [CFG_W-1:0]         kap_reg, isq_reg, stf_reg;
    logic signed [DATA_W-1:0] win_reg [3][4];
    logic signed [DATA_W-1:0] cur_reg [3];
    logic [CNT_W-1:0]         seen_reg;
    logic                     end_reg;

    // intermediate results
    logic signed [DATA_W-1:0] p12_reg, p_reg, pp_reg, den_reg, den2_reg, mp_reg;
    logic signed [DATA_W-1:0] dp_reg [3];
    logic signed [DATA_W-1:0] g_reg [3];
    logic signed [DATA_W-1:0] lap_reg [3];
    logic signed [DATA_W-1:0] bih_reg [3];
    logic signed [DATA_W-1:0] acc_reg [3];
    logic                     cl_reg;

    // output register
    logic                       ov_reg;
    logic [OUT_TDATA_W-1:0]     od_reg;
    logic                       ou_reg, ol_reg;

    // shared multiplier: magnitudes, four 24x24 partial products
    logic signed [DATA_W-1:0] ma_reg, mb_reg;
    logic [DATA_W-1:0]        am_reg, bm_reg;
    logic                     mneg_reg;
    logic [1:0]               mph_reg;
    logic [2*DATA_W-1:0]      macc_reg;
    logic [23:0]              pa, pb;
    logic [47:0]              pprod;
    logic [2*DATA_W-1:0]      pshift;

    // divider
    logic [DIVN-1:0]          dn_reg, dq_reg;
    logic [DATA_W:0]          drem_reg;
    logic [DATA_W-1:0]        dd_reg;
    logic                     dneg_reg, dzero_reg;
    logic [DCW-1:0]           dcnt_reg;
    logic [1:0]               qi_reg;
    logic [DATA_W:0]          dtry;
    logic [DATA_W+1:0]        dsub;

    logic in_fire, out_fire;
    logic ov_set;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    // result register is loaded this cycle
    assign ov_set = (!ov_reg || out_fire)
                    && (((state_reg == S_EMIT) && (seen_reg >= CNT_W'(2)))
                        || (state_reg == S_FLUSH1) || (state_reg == S_FLUSH2));

    // partial product select
    always_comb
    begin
        pa = mph_reg[0] ? am_reg[47:24] : am_reg[23:0];
        pb = mph_reg[1] ? bm_reg[47:24] : bm_reg[23:0];
        pprod = pa * pb;
        pshift = {48'd0, pprod} << (24 * (32'(mph_reg[0]) + 32'(mph_reg[1])));
    end

    // finished product: floor shift, saturate
    logic [2*DATA_W-1:0] mq;
    logic                mrem;
    logic [2*DATA_W-1:0] mqa;
    logic signed [DATA_W-1:0] mres;
    logic                mclip;
    always_comb
    begin
        mq   = macc_reg >> FRAC_BITS;
        mrem = |(macc_reg & ((96'd1 << FRAC_BITS) - 96'd1));
        mqa  = mq + ((mneg_reg && mrem) ? 96'd1 : 96'd0);
        mclip = 1'b0;
        if (mneg_reg) begin
            if (mqa > 96'h800000000000) begin
                mclip = 1'b1;
                mres  = SMIN;
            end else begin
                mres = -$signed(mqa[DATA_W-1:0]);
            end
        end else begin
            if (mqa > 96'h7FFFFFFFFFFF) begin
                mclip = 1'b1;
                mres  = SMAX;
            end else begin
                mres = $signed(mqa[DATA_W-1:0]);
            end
        end
    end

    // operand select for each step
    logic signed [DATA_W-1:0] opa, opb;
    logic [DATA_W:0] d2s [3];
    logic [DATA_W:0] d4s [3];
    logic [DATA_W:0] dens;
    always_comb
    begin
        for (int f = 0; f < 3; f++) begin
            d2s[f] = sat_wide((DATA_W+4)'(win_reg[f][3]) - 2 * (DATA_W+4)'(win_reg[f][2])
                             + (DATA_W+4)'(win_reg[f][1]));
            d4s[f] = sat_wide((DATA_W+4)'(win_reg[f][0]) - 4 * (DATA_W+4)'(win_reg[f][1])
                             + 6 * (DATA_W+4)'(win_reg[f][2]) - 4 * (DATA_W+4)'(win_reg[f][3])
                             + (DATA_W+4)'(cur_reg[f]));
        end
        dens = sat_wide((DATA_W+4)'(ONE) + (DATA_W+4)'(mres));
        opa = '0;
        opb = '0;
        unique case (step_reg)
            U_P12:  begin opa = win_reg[0][2]; opb = win_reg[1][2]; end
            U_P:    begin opa = p12_reg; opb = win_reg[2][2]; end
            U_PP:   begin opa = p_reg; opb = p_reg; end
            U_KPP:  begin opa = $signed({1'b0, kap_reg}); opb = pp_reg; end
            U_DEN2: begin opa = den_reg; opb = den_reg; end
            U_MP:   begin opa = pot_reg; opb = p_reg; end
            U_DP0:  begin opa = win_reg[1][2]; opb = win_reg[2][2]; end
            U_DP1:  begin opa = win_reg[0][2]; opb = win_reg[2][2]; end
            U_DP2:  begin opa = win_reg[0][2]; opb = win_reg[1][2]; end
            U_G0:   begin opa = mp_reg; opb = dp_reg[0]; end
            U_G1:   begin opa = mp_reg; opb = dp_reg[1]; end
            U_G2:   begin opa = mp_reg; opb = dp_reg[2]; end
            U_LAP0: begin opa = d2s[0][DATA_W-1:0]; opb = $signed({1'b0, isq_reg}); end
            U_BIH0: begin opa = d4s[0][DATA_W-1:0]; opb = $signed({1'b0, stf_reg}); end
            U_LAP1: begin opa = d2s[1][DATA_W-1:0]; opb = $signed({1'b0, isq_reg}); end
            U_BIH1: begin opa = d4s[1][DATA_W-1:0]; opb = $signed({1'b0, stf_reg}); end
            U_LAP2: begin opa = d2s[2][DATA_W-1:0]; opb = $signed({1'b0, isq_reg}); end
            U_BIH2: begin opa = d4s[2][DATA_W-1:0]; opb = $signed({1'b0, stf_reg}); end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    // stencil sum clip flag for the current step
    logic sclip;
    always_comb
    begin
        sclip = 1'b0;
        unique case (step_reg)
            U_LAP0: sclip = d2s[0][DATA_W];
            U_BIH0: sclip = d4s[0][DATA_W];
            U_LAP1: sclip = d2s[1][DATA_W];
            U_BIH1: sclip = d4s[1][DATA_W];
            U_LAP2: sclip = d2s[2][DATA_W];
            U_BIH2: sclip = d4s[2][DATA_W];
            default: sclip = 1'b0;
        endcase
    end

    // divider step and finish
    logic [DATA_W:0] asum;
    logic [DIVN-1:0] qfin;
    logic signed [DATA_W-1:0] qres;
    logic qclip;
    always_comb
    begin
        dtry = {drem_reg[DATA_W-1:0], dn_reg[DIVN-1]};
        dsub = {1'b0, dtry} - {2'b00, dd_reg};
        qfin = dq_reg;
        qclip = 1'b0;
        if (dzero_reg) begin
            qres = '0;
        end else if (dneg_reg) begin
            if (qfin > DIVN'(49'h800000000000)) begin
                qclip = 1'b1;
                qres = SMIN;
            end else begin
                qres = -$signed(qfin[DATA_W-1:0]);
            end
        end else begin
            if (qfin > DIVN'(48'h7FFFFFFFFFFF)) begin
                qclip = 1'b1;
                qres = SMAX;
            end else begin
                qres = $signed(qfin[DATA_W-1:0]);
            end
        end
        asum = sat_wide((DATA_W+4)'(lap_reg[qi_reg]) - (DATA_W+4)'(bih_reg[qi_reg])
                        - (DATA_W+4)'(qres));
    end

    logic signed [DATA_W-1:0] gsel, gmag;
    assign gsel = g_reg[qi_reg];
    assign gmag = gsel[DATA_W-1] ? -gsel : gsel;

    // sequencer, datapath and register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= U_P12;
            pot_reg   <= -48'sd167772160;
            kap_reg   <= 47'd16777216;
            isq_reg   <= 47'd41901107446;
            stf_reg   <= 47'd1046480357949;
            seen_reg  <= '0;
            end_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            for (int f = 0; f < 3; f++)
                for (int j = 0; j < 4; j++)
                    win_reg[f][j] <= '0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_POT:   pot_reg <= $signed(cfg_data);
                    REG_SAT:   kap_reg <= cfg_data[CFG_W-1:0];
                    REG_ISPSQ: isq_reg <= cfg_data[CFG_W-1:0];
                    REG_STIFF: stf_reg <= cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (out_fire && !ov_set)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        for (int f = 0; f < 3; f++)
                            cur_reg[f] <= $signed(s_axis_tdata[f*DATA_W +: DATA_W]);
                        end_reg <= s_axis_tlast;
                        cl_reg  <= 1'b0;
                        if (seen_reg >= CNT_W'(4)) begin
                            step_reg  <= U_P12;
                            mph_reg   <= 2'd0;
                            state_reg <= S_MWAIT;
                        end else begin
                            for (int f = 0; f < 3; f++)
                                acc_reg[f] <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                // latch operand magnitudes
                S_MWAIT: begin
                    am_reg   <= opa[DATA_W-1] ? DATA_W'(-opa) : DATA_W'(opa);
                    bm_reg   <= opb[DATA_W-1] ? DATA_W'(-opb) : DATA_W'(opb);
                    mneg_reg <= opa[DATA_W-1] ^ opb[DATA_W-1];
                    macc_reg <= '0;
                    mph_reg  <= 2'd0;
                    cl_reg   <= cl_reg | sclip;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    macc_reg <= macc_reg + pshift;
                    mph_reg  <= mph_reg + 2'd1;
                    if (mph_reg == 2'd3) begin
                        state_reg <= S_DFIN;
                    end
                end
                // store product, advance step
                S_DFIN: begin
                    cl_reg <= cl_reg | mclip | ((step_reg == U_KPP) && dens[DATA_W]);
                    state_reg <= S_MWAIT;
                    unique case (step_reg)
                        U_P12:  p12_reg <= mres;
                        U_P:    p_reg <= mres;
                        U_PP:   pp_reg <= mres;
                        U_KPP:  den_reg <= dens[DATA_W-1:0];
                        U_DEN2: den2_reg <= mres;
                        U_MP:   mp_reg <= mres;
                        U_DP0:  dp_reg[0] <= mres;
                        U_DP1:  dp_reg[1] <= mres;
                        U_DP2:  dp_reg[2] <= mres;
                        U_G0:   g_reg[0] <= mres;
                        U_G1:   g_reg[1] <= mres;
                        U_G2:   g_reg[2] <= mres;
                        U_LAP0: lap_reg[0] <= mres;
                        U_BIH0: bih_reg[0] <= mres;
                        U_LAP1: lap_reg[1] <= mres;
                        U_BIH1: bih_reg[1] <= mres;
                        U_LAP2: lap_reg[2] <= mres;
                        default: bih_reg[2] <= mres;
                    endcase
                    if (step_reg == U_BIH2) begin
                        step_reg <= U_Q0;
                        qi_reg   <= 2'd0;
                        state_reg <= S_DIV;
                        dcnt_reg <= '0;
                    end else begin
                        step_reg <= step_t'(step_reg + 5'd1);
                    end
                end
                // restoring divider, one bit per cycle
                S_DIV: begin
                    if (dcnt_reg == '0) begin
                        dn_reg    <= {gmag, {FRAC_BITS{1'b0}}};
                        dq_reg    <= '0;
                        drem_reg  <= '0;
                        dd_reg    <= den2_reg;
                        dneg_reg  <= gsel[DATA_W-1];
                        dzero_reg <= (den2_reg[DATA_W-1] || den2_reg == '0);
                        dcnt_reg  <= DCW'(1);
                    end else if (dcnt_reg <= DCW'(DIVN)) begin
                        dn_reg <= dn_reg << 1;
                        if (!dsub[DATA_W+1]) begin
                            drem_reg <= dsub[DATA_W:0];
                            dq_reg   <= {dq_reg[DIVN-2:0], 1'b1};
                        end else begin
                            drem_reg <= dtry;
                            dq_reg   <= {dq_reg[DIVN-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg + DCW'(1);
                    end else begin
                        acc_reg[qi_reg] <= asum[DATA_W-1:0];
                        cl_reg <= cl_reg | (qclip & !dzero_reg) | asum[DATA_W];
                        dcnt_reg <= '0;
                        if (qi_reg == 2'd2)
                            state_reg <= S_EMIT;
                        qi_reg <= qi_reg + 2'd1;
                    end
                end
                // result for point k-2, then window update or flush
                S_EMIT: begin
                    if (!ov_reg || out_fire) begin
                        if (seen_reg >= CNT_W'(2)) begin
                            ov_reg <= 1'b1;
                            od_reg <= {acc_reg[2], acc_reg[1], acc_reg[0]};
                            ou_reg <= (seen_reg >= CNT_W'(4)) ? cl_reg : 1'b0;
                            ol_reg <= 1'b0;
                        end
                        if (end_reg) begin
                            state_reg <= (seen_reg >= CNT_W'(1)) ? S_FLUSH1 : S_FLUSH2;
                        end else begin
                            for (int f = 0; f < 3; f++) begin
                                win_reg[f][0] <= win_reg[f][1];
                                win_reg[f][1] <= win_reg[f][2];
                                win_reg[f][2] <= win_reg[f][3];
                                win_reg[f][3] <= cur_reg[f];
                            end
                            if (seen_reg < CNT_W'(MAX_ROW))
                                seen_reg <= seen_reg + CNT_W'(1);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FLUSH1: begin
                    if (!ov_reg || out_fire) begin
                        ov_reg <= 1'b1;
                        od_reg <= '0;
                        ou_reg <= 1'b0;
                        ol_reg <= 1'b0;
                        state_reg <= S_FLUSH2;
                    end
                end
                default: begin
                    if (!ov_reg || out_fire) begin
                        ov_reg <= 1'b1;
                        od_reg <= '0;
                        ou_reg <= 1'b0;
                        ol_reg <= 1'b1;
                        seen_reg <= '0;
                        for (int f = 0; f < 3; f++)
                            for (int j = 0; j < 4; j++)
                                win_reg[f][j] <= '0;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTH
    // input taken only between points
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE)) else $error("input ready while busy");
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // counter stays bounded
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_W'(MAX_ROW)) else $error("point counter overrun");
    // divider counter bounded
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DCW'(DIVN + 1)) else $error("divider counter overrun");
`endif

endmodule
